// File: design/positional_list_store_unit_macros.svh
// Assertion macros for the positional list store unit.
`ifndef POSITIONAL_LIST_STORE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_STORE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, idle in reset.
`define PLS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("positional list store: check failed");

// Next-cycle implication, sampled on clk_i, idle in reset.
`define PLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("positional list store: check failed");

`endif

// File: design/pls_pkg.sv
// Package: types and constants shared by the positional list store unit.
`timescale 1ns / 1ps
package pls_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IdxW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WordW   = 32;
  localparam int unsigned PosW    = 5;
  localparam int unsigned CountW  = 5;
  localparam int unsigned KindW   = 3;
  localparam int unsigned StatusW = 2;

  typedef enum logic [KindW-1:0] {
    KIND_READ   = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_e;

  // What every cell of the chain does this cycle.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,  // keep word
    CELL_LOAD  = 2'd1,  // overwrite the addressed cell
    CELL_OPEN  = 2'd2,  // insert: shift up from the addressed cell
    CELL_CLOSE = 2'd3   // delete: shift down into the addressed cell
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [IdxW-1:0]    idx;
    logic [WordW-1:0]   value;
  } cell_ctrl_t;

endpackage

// File: design/positional_list_store_unit.sv
// Positional list store: bounded ordered word list held in a shifting cell chain.
// Result: registered, valid in the cycle after its request beat is taken.
// Throughput: one request per cycle while results are taken; the chain shifts a whole insert or delete at once.
// A stalled result register holds in_ready_o low until out_ready_i takes it.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending result;
// cell contents are not cleared and are never read beyond the fill count.
`timescale 1ns / 1ps
module positional_list_store_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pls_pkg::KindW-1:0]         kind_i,
  input  logic [pls_pkg::PosW-1:0]          position_i,
  input  logic signed [pls_pkg::WordW-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pls_pkg::WordW-1:0]  data_o,
  output logic [pls_pkg::StatusW-1:0]       status_o,
  output logic [pls_pkg::CountW-1:0]        count_o
);

`include "positional_list_store_unit_macros.svh"

  localparam logic [pls_pkg::CountW-1:0] FullCount = pls_pkg::CountW'(pls_pkg::DEPTH);

  logic                          in_fire;
  logic [pls_pkg::CountW-1:0]    fill_q, fill_d;
  logic                          out_valid_q;
  logic [pls_pkg::WordW-1:0]     data_q, res_data;
  pls_pkg::status_e              status_q, res_status;
  logic [pls_pkg::CountW-1:0]    count_q;
  pls_pkg::cell_ctrl_t           ctrl;
  pls_pkg::cell_op_e             req_op;
  logic [pls_pkg::PosW-1:0]      pos_eff, pos_m1;
  logic [pls_pkg::CountW:0]      fill_p1;
  logic [pls_pkg::WordW-1:0]     words [pls_pkg::DEPTH];
  logic [pls_pkg::WordW-1:0]     rd_word;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Position zero maps to the head for read and write; insert and delete reject it as out of range
  assign pos_eff = (position_i == '0) ? pls_pkg::PosW'(1) : position_i;
  assign pos_m1  = pos_eff - pls_pkg::PosW'(1);
  assign fill_p1 = {1'b0, fill_q} + (pls_pkg::CountW + 1)'(1);
  assign rd_word = words[pos_m1[pls_pkg::IdxW-1:0]];

  // Request decode: status, returned word, cell op and new fill
  always_comb begin
    req_op     = pls_pkg::CELL_HOLD;
    res_data   = '0;
    res_status = pls_pkg::STATUS_OK;
    fill_d     = fill_q;
    case (pls_pkg::kind_e'(kind_i))
      pls_pkg::KIND_READ: begin
        if (pos_eff > fill_q) begin
          res_status = pls_pkg::STATUS_RANGE;
        end else begin
          res_data = rd_word;
        end
      end
      pls_pkg::KIND_WRITE: begin
        if (pos_eff > fill_q) begin
          res_status = pls_pkg::STATUS_RANGE;
        end else begin
          req_op = pls_pkg::CELL_LOAD;
        end
      end
      pls_pkg::KIND_INSERT: begin
        if (fill_q >= FullCount) begin
          res_status = pls_pkg::STATUS_FULL;
        end else if (position_i == '0 || {1'b0, position_i} > fill_p1) begin
          res_status = pls_pkg::STATUS_RANGE;
        end else begin
          req_op = pls_pkg::CELL_OPEN;
          fill_d = fill_p1[pls_pkg::CountW-1:0];
        end
      end
      pls_pkg::KIND_DELETE: begin
        if (fill_q == '0) begin
          res_status = pls_pkg::STATUS_EMPTY;
        end else if (position_i == '0 || position_i > fill_q) begin
          res_status = pls_pkg::STATUS_RANGE;
        end else begin
          res_data = rd_word;
          req_op   = pls_pkg::CELL_CLOSE;
          fill_d   = fill_q - pls_pkg::CountW'(1);
        end
      end
      pls_pkg::KIND_CLEAR: begin
        fill_d = '0;
      end
      default: begin
        req_op = pls_pkg::CELL_HOLD;
      end
    endcase
  end

  // Broadcast to the chain only on an accepted beat
  always_comb begin
    ctrl.op    = in_fire ? req_op : pls_pkg::CELL_HOLD;
    ctrl.idx   = pos_m1[pls_pkg::IdxW-1:0];
    ctrl.value = value_i;
  end

  // Cell chain: each cell sees its lower and upper neighbor (the head takes value_i, the tail itself)
  for (genvar i = 0; i < pls_pkg::DEPTH; i++) begin : g_cell
    logic [pls_pkg::WordW-1:0] prev_w, next_w;
    if (i == 0) begin : g_head
      assign prev_w = value_i;
    end else begin : g_body_prev
      assign prev_w = words[i-1];
    end
    if (i == pls_pkg::DEPTH - 1) begin : g_tail
      assign next_w = words[i];
    end else begin : g_body_next
      assign next_w = words[i+1];
    end
    pls_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .index_i (pls_pkg::IdxW'(i)),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .word_o  (words[i])
    );
  end

  // Fill count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) fill_q <= fill_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q   <= res_data;
      status_q <= res_status;
      count_q  <= fill_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = data_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

  // Checks
  `PLS_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FullCount)
  `PLS_ASSERT_NEXT(a_count_tracks_fill, in_fire, count_o == fill_q)
  `PLS_ASSERT_NEXT(a_full_flag, in_fire && kind_i == pls_pkg::KIND_INSERT && fill_q == FullCount, status_o == pls_pkg::STATUS_FULL)

endmodule

// File: design/pls_cell.sv
// One storage cell of the shifting list chain.
`timescale 1ns / 1ps
module pls_cell (
  input  logic                              clk_i,
  input  pls_pkg::cell_ctrl_t               ctrl_i,
  input  logic [pls_pkg::IdxW-1:0]          index_i,
  input  logic [pls_pkg::WordW-1:0]         prev_i,
  input  logic [pls_pkg::WordW-1:0]         next_i,
  output logic [pls_pkg::WordW-1:0]         word_o
);

  logic [pls_pkg::WordW-1:0] word_q, word_d;

  // Pick the new word from the broadcast op and this cell's place
  always_comb begin
    word_d = word_q;
    case (ctrl_i.op)
      pls_pkg::CELL_LOAD: begin
        if (index_i == ctrl_i.idx) word_d = ctrl_i.value;
      end
      pls_pkg::CELL_OPEN: begin
        if (index_i > ctrl_i.idx) begin
          word_d = prev_i;
        end else if (index_i == ctrl_i.idx) begin
          word_d = ctrl_i.value;
        end
      end
      pls_pkg::CELL_CLOSE: begin
        if (index_i >= ctrl_i.idx) word_d = next_i;
      end
      default: word_d = word_q;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// File: tb/tb_positional_list_store_unit.sv
// Testbench for positional_list_store_unit: random and directed requests checked by a list model.
`timescale 1ns / 1ps
module tb_positional_list_store_unit;

  // Request codes the block treats as no operation.
  localparam logic [pls_pkg::KindW-1:0] KIND_NOP_A = 3'd5;
  localparam logic [pls_pkg::KindW-1:0] KIND_NOP_B = 3'd6;
  localparam logic [pls_pkg::KindW-1:0] KIND_NOP_C = 3'd7;

  localparam logic signed [pls_pkg::WordW-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [pls_pkg::WordW-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  localparam int RANDOM_REQS = 470;
  localparam int HOLD_AT     = 60;   // result count at which the receiver holds off
  localparam int LONG_HOLD   = 40;   // cycles of that hold-off

  typedef struct {
    logic [pls_pkg::KindW-1:0]        kind;
    logic [pls_pkg::PosW-1:0]         pos;
    logic signed [pls_pkg::WordW-1:0] value;
    int                               gap;
    bit                               drain;  // wait for all results before offering
  } list_req_t;

  typedef struct {
    logic signed [pls_pkg::WordW-1:0] data;
    pls_pkg::status_e                 status;
    logic [pls_pkg::CountW-1:0]       count;
  } list_result_t;

  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 in_valid_i  = 1'b0;
  logic                                 in_ready_o;
  logic [pls_pkg::KindW-1:0]            kind_i      = '0;
  logic [pls_pkg::PosW-1:0]             position_i  = '0;
  logic signed [pls_pkg::WordW-1:0]     value_i     = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic signed [pls_pkg::WordW-1:0]     data_o;
  logic [pls_pkg::StatusW-1:0]          status_o;
  logic [pls_pkg::CountW-1:0]           count_o;

  list_req_t    req_q[$];
  list_result_t result_q[$];

  // List model state
  logic signed [pls_pkg::WordW-1:0] list_words [pls_pkg::DEPTH];
  int                               list_len = 0;

  int  err_cnt = 0;
  int  req_beats = 0;
  int  result_beats = 0;
  int  status_hits [4] = '{0, 0, 0, 0};
  int  peak_len = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  int  gen_idx = 0;
  int  gen_fill = 0;

  positional_list_store_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one request to the list model and return the answer it gives.
  task automatic list_apply(input logic [pls_pkg::KindW-1:0] kind,
                            input logic [pls_pkg::PosW-1:0] pos_in,
                            input logic signed [pls_pkg::WordW-1:0] val,
                            output list_result_t res);
    int pos;
    int k;
    pos        = int'(pos_in);
    res.data   = '0;
    res.status = pls_pkg::STATUS_OK;
    case (kind)
      pls_pkg::KIND_READ, pls_pkg::KIND_WRITE: begin
        if (pos == 0) pos = 1;
        if (pos > list_len) begin
          res.status = pls_pkg::STATUS_RANGE;
        end else if (kind == pls_pkg::KIND_READ) begin
          res.data = list_words[pos-1];
        end else begin
          list_words[pos-1] = val;
        end
      end
      pls_pkg::KIND_INSERT: begin
        if (list_len >= pls_pkg::DEPTH) begin
          res.status = pls_pkg::STATUS_FULL;
        end else if (pos == 0 || pos > list_len + 1) begin
          res.status = pls_pkg::STATUS_RANGE;
        end else begin
          for (k = list_len; k > pos - 1; k--) list_words[k] = list_words[k-1];
          list_words[pos-1] = val;
          list_len++;
        end
      end
      pls_pkg::KIND_DELETE: begin
        if (list_len == 0) begin
          res.status = pls_pkg::STATUS_EMPTY;
        end else if (pos == 0 || pos > list_len) begin
          res.status = pls_pkg::STATUS_RANGE;
        end else begin
          res.data = list_words[pos-1];
          for (k = pos - 1; k < list_len - 1; k++) list_words[k] = list_words[k+1];
          list_len--;
        end
      end
      pls_pkg::KIND_CLEAR: list_len = 0;
      default: ;
    endcase
    res.count = list_len[pls_pkg::CountW-1:0];
  endtask

  // Queue one request; gaps vanish for requests 120 to 199 of the sequence.
  task automatic queue_req(input logic [pls_pkg::KindW-1:0] kind,
                           input logic [pls_pkg::PosW-1:0] pos,
                           input logic signed [pls_pkg::WordW-1:0] val, input bit drain);
    list_req_t r;
    r.kind  = kind;
    r.pos   = pos;
    r.value = val;
    r.drain = drain;
    r.gap   = (gen_idx >= 120 && gen_idx < 200) ? 0 : $urandom_range(5, 0);
    req_q.push_back(r);
    gen_idx++;
    // track the fill so random positions stay meaningful
    case (kind)
      pls_pkg::KIND_INSERT:
        if (gen_fill < pls_pkg::DEPTH && pos >= 1 && pos <= gen_fill + 1) gen_fill++;
      pls_pkg::KIND_DELETE: if (gen_fill > 0 && pos >= 1 && pos <= gen_fill) gen_fill--;
      pls_pkg::KIND_CLEAR:  gen_fill = 0;
      default: ;
    endcase
  endtask

  function automatic logic signed [pls_pkg::WordW-1:0] pick_word();
    case ($urandom_range(19, 0))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Monitor: check result beats, then model request beats.
  always @(posedge clk_i) begin : mon_proc
    list_result_t got_exp;
    list_result_t new_exp;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        out_taken = 1'b1;
        result_beats++;
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected: data %0d status %0d count %0d",
                 data_o, status_o, count_o);
          err_cnt++;
        end else begin
          got_exp = result_q.pop_front();
          if (data_o !== got_exp.data) begin
            $error("data: expected %0d, got %0d", got_exp.data, data_o);
            err_cnt++;
          end
          if (status_o !== got_exp.status) begin
            $error("status: expected %0d, got %0d", got_exp.status, status_o);
            err_cnt++;
          end
          if (count_o !== got_exp.count) begin
            $error("count: expected %0d, got %0d", got_exp.count, count_o);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        in_taken = 1'b1;
        req_beats++;
        list_apply(kind_i, position_i, value_i, new_exp);
        status_hits[new_exp.status]++;
        if (list_len > peak_len) peak_len = list_len;
        result_q.push_back(new_exp);
      end
    end
  end

  // Driver: present the next pending request at the falling edge.
  always @(negedge clk_i) begin : drv_proc
    list_req_t nxt;
    bit        offer;
    offer = 1'b0;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (req_q.size() > 0) begin
        if (req_q[0].drain && result_q.size() > 0) begin
          offer = 1'b0;
        end else if (req_q[0].gap > 0) begin
          req_q[0].gap = req_q[0].gap - 1;
        end else begin
          nxt   = req_q.pop_front();
          offer = 1'b1;
        end
      end
      if (offer) begin
        kind_i     <= nxt.kind;
        position_i <= nxt.pos;
        value_i    <= nxt.value;
      end
      in_valid_i <= offer;
    end
  end

  // Receiver: random stall per result, one long hold-off, one stretch with no stalls.
  always @(negedge clk_i) begin : rcv_proc
    int stall_left;
    int hold_left;
    if (rst_ni) begin
      if (out_taken) begin
        if (result_beats == HOLD_AT) hold_left = LONG_HOLD;
        else if (result_beats >= 250 && result_beats < 330) stall_left = 0;
        else stall_left = $urandom_range(5, 0);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin : stim_proc
    logic [pls_pkg::KindW-1:0] kind;
    logic [pls_pkg::PosW-1:0]  pos;
    int                        r;
    bit                        grow;

    // directed: empty list corners, front push, append, position zero, range limits
    queue_req(pls_pkg::KIND_READ,   5'd0,  32'sd0, 1'b0);
    queue_req(pls_pkg::KIND_DELETE, 5'd1,  32'sd0, 1'b0);
    queue_req(pls_pkg::KIND_INSERT, 5'd0,  32'sd7, 1'b0);
    queue_req(pls_pkg::KIND_INSERT, 5'd2,  32'sd7, 1'b0);
    queue_req(pls_pkg::KIND_INSERT, 5'd1,  WORD_MAX, 1'b0);
    queue_req(pls_pkg::KIND_INSERT, 5'd1,  WORD_MIN, 1'b0);
    queue_req(pls_pkg::KIND_INSERT, 5'd3,  -32'sd1, 1'b0);
    queue_req(pls_pkg::KIND_READ,   5'd0,  32'sd0, 1'b0);
    queue_req(pls_pkg::KIND_READ,   5'd4,  32'sd0, 1'b0);
    queue_req(pls_pkg::KIND_WRITE,  5'd0,  32'sh5A5A_A5A5, 1'b0);
    queue_req(pls_pkg::KIND_WRITE,  5'd31, 32'sh1234_5678, 1'b0);
    queue_req(pls_pkg::KIND_DELETE, 5'd0,  32'sd0, 1'b0);
    queue_req(pls_pkg::KIND_DELETE, 5'd4,  32'sd0, 1'b0);
    queue_req(pls_pkg::KIND_DELETE, 5'd2,  32'sd0, 1'b0);
    queue_req(KIND_NOP_A,           5'd31, WORD_MAX, 1'b0);
    queue_req(KIND_NOP_B,           5'd1,  WORD_MIN, 1'b0);
    queue_req(KIND_NOP_C,           5'd16, -32'sd1, 1'b0);
    queue_req(pls_pkg::KIND_CLEAR,  5'd31, -32'sd1, 1'b1);
    // fill to the top, then hit the full and tail cases
    for (int i = 0; i < pls_pkg::DEPTH; i++) begin
      queue_req(pls_pkg::KIND_INSERT, 5'(i + 1), $urandom, 1'b0);
    end
    queue_req(pls_pkg::KIND_INSERT, 5'd0,  32'sd1, 1'b0);
    queue_req(pls_pkg::KIND_READ,   5'd16, 32'sd0, 1'b0);
    queue_req(pls_pkg::KIND_READ,   5'd17, 32'sd0, 1'b0);
    queue_req(pls_pkg::KIND_DELETE, 5'd16, 32'sd0, 1'b0);

    // random: grow and shrink phases of well-formed requests plus some noise
    for (int i = 0; i < RANDOM_REQS; i++) begin
      grow = ((i / 40) % 2) == 0;
      r    = $urandom_range(99, 0);
      if (r < 12) begin
        kind = pls_pkg::KindW'($urandom_range(7, 0));
        pos  = pls_pkg::PosW'($urandom_range(31, 0));
      end else if (r < 14) begin
        kind = pls_pkg::KIND_CLEAR;
        pos  = pls_pkg::PosW'($urandom_range(31, 0));
      end else begin
        r = $urandom_range(99, 0);
        if (r < 55)      kind = grow ? pls_pkg::KIND_INSERT : pls_pkg::KIND_DELETE;
        else if (r < 70) kind = grow ? pls_pkg::KIND_DELETE : pls_pkg::KIND_INSERT;
        else if (r < 85) kind = pls_pkg::KIND_READ;
        else             kind = pls_pkg::KIND_WRITE;
        if (kind == pls_pkg::KIND_INSERT) pos = pls_pkg::PosW'($urandom_range(gen_fill + 1, 1));
        else if (gen_fill == 0)           pos = 5'd1;
        else                              pos = pls_pkg::PosW'($urandom_range(gen_fill, 1));
        if ((kind == pls_pkg::KIND_READ || kind == pls_pkg::KIND_WRITE) &&
            $urandom_range(9, 0) == 0) pos = '0;
      end
      queue_req(kind, pos, pick_word(), (i % 100) == 50);
    end

    // reset once, released at a falling edge
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain, then let the pipeline settle
    while (req_q.size() > 0 || in_valid_i || result_q.size() > 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (result_q.size() != 0) begin
      $error("%0d results never arrived", result_q.size());
      err_cnt++;
    end

    $display("Covered %0d requests and %0d results; peak list length %0d of %0d.",
             req_beats, result_beats, peak_len, pls_pkg::DEPTH);
    $display("Status mix: ok %0d, out of range %0d, full %0d, empty %0d.",
             status_hits[pls_pkg::STATUS_OK], status_hits[pls_pkg::STATUS_RANGE],
             status_hits[pls_pkg::STATUS_FULL], status_hits[pls_pkg::STATUS_EMPTY]);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog_proc
    #200000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
